### src/frvm_pkg.sv
// Shared constants, codes and types of the frame register virtual machine.
package frvm_pkg;

   localparam int DATA_DEPTH  = 1024;
   localparam int FRAME_DEPTH = 64;
   localparam int PC_WIDTH    = 16;
   localparam int WORD_WIDTH  = 32;

   localparam int DATA_AW   = $clog2(DATA_DEPTH);
   localparam int FRAME_AW  = $clog2(FRAME_DEPTH);
   localparam int FCOUNT_W  = $clog2(FRAME_DEPTH + 1);
   localparam int ASUM_W    = DATA_AW + 9;
   localparam int SUM_W     = ((WORD_WIDTH > 32) ? WORD_WIDTH : 32) + 1;

   localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};

   localparam logic [3:0] OP_SOFTBRK = 4'd0;
   localparam logic [3:0] OP_BREAK   = 4'd1;
   localparam logic [3:0] OP_HALT    = 4'd2;
   localparam logic [3:0] OP_ADDC    = 4'd3;
   localparam logic [3:0] OP_TEST    = 4'd4;
   localparam logic [3:0] OP_CONST   = 4'd5;
   localparam logic [3:0] OP_JMP     = 4'd6;
   localparam logic [3:0] OP_JMPC    = 4'd7;
   localparam logic [3:0] OP_PREPARE = 4'd8;
   localparam logic [3:0] OP_ARG     = 4'd9;
   localparam logic [3:0] OP_EXEC    = 4'd10;
   localparam logic [3:0] OP_RET     = 4'd11;

   localparam logic [1:0] ERR_OK      = 2'd0;
   localparam logic [1:0] ERR_FRAMES  = 2'd1;
   localparam logic [1:0] ERR_DATA    = 2'd2;
   localparam logic [1:0] ERR_MISSING = 2'd3;

   // The base keeps one bit above the data address, since a frame may start
   // exactly at the end of the data memory.
   typedef struct packed {
      logic [DATA_AW:0]    base;
      logic [7:0]          ret_reg;
      logic [PC_WIDTH-1:0] link_pc;
   } frame_type;

   typedef struct packed {
      logic [15:0] next_address;
      logic        stop;
      logic        halted;
      logic [1:0]  error_code;
   } result_type;

endpackage

### src/frvm_if.sv
// Request and response channel interfaces of the virtual machine step block.
interface frvm_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         opcode;
   logic [7:0]         target_reg;
   logic [7:0]         source_reg;
   logic [7:0]         second_reg;
   logic signed [31:0] constant_value;
   logic signed [15:0] jump_offset;
   logic [7:0]         frame_size;
   logic [15:0]        entry_address;

   modport source (output valid, opcode, target_reg, source_reg, second_reg,
                   constant_value, jump_offset, frame_size, entry_address,
                   input ready);
   modport sink (input valid, opcode, target_reg, source_reg, second_reg,
                 constant_value, jump_offset, frame_size, entry_address,
                 output ready);
endinterface

interface frvm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_address;
   logic        stop;
   logic        halted;
   logic [1:0]  error_code;

   modport source (output valid, next_address, stop, halted, error_code, input ready);
   modport sink (input valid, next_address, stop, halted, error_code, output ready);
endinterface

### src/frvm_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
module frvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### src/frame_register_vm_step_top.sv
// Top level of the frame register virtual machine: sequencer around data and frame RAMs.
//
//   channel  direction  handshake            contents
//   req_bus  in         valid/ready          one instruction and its fields
//   rsp_bus  out        valid/ready          next address, stop, halted, error code
//   csr      in         csr_we, csr_wdata    stepping enable bit
//
// The result passes through the states F1, F2, D1 and D2 to OUT, where it waits for a free
// output register; the next instruction is taken once the sequencer is back in idle. Prepare
// adds the clear state ST_CLR, where the zero fill goes one word a cycle through the single
// write port of the data RAM. The frame RAM and data RAM each give one read per cycle,
// which sets the read sequence. Reset is synchronous and clears the control state only;
// both RAMs hold no meaningful content until written. A new instruction is taken while a
// finished result still waits in the output register.
module frame_register_vm_step_top
   import frvm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   frvm_req_if.sink      req_bus,
   frvm_rsp_if.source    rsp_bus,
   input  logic          csr_we,
   input  logic          csr_wdata
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_F1   = 7'b0000010,
      ST_F2   = 7'b0000100,
      ST_D1   = 7'b0001000,
      ST_D2   = 7'b0010000,
      ST_CLR  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Latched instruction fields.
   logic [3:0]            op_ff;
   logic [7:0]            tr_ff, sr_ff, qr_ff, fsize_ff;
   logic [31:0]           cst_ff;
   logic [15:0]           off_ff, entry_ff;

   // Architectural state kept in flip-flops.
   logic [PC_WIDTH-1:0]   pc_ff;
   logic [FCOUNT_W-1:0]   fcount_ff;
   logic [DATA_AW:0]      dtop_ff;
   logic                  step_ff;

   // Working registers of the sequence.
   frame_type             top_ff;
   logic [1:0]            err_ff;
   logic [DATA_AW-1:0]    at_ff, aq_ff;
   logic [WORD_WIDTH-1:0] adata_ff;
   logic [DATA_AW-1:0]    clr_addr_ff;
   logic [7:0]            clr_left_ff;
   result_type            res_ff;
   result_type            rsp_ff;
   logic                  rsp_valid_ff;

   // RAM ports.
   logic                  f_we;
   logic [FRAME_AW-1:0]   f_waddr, f_raddr;
   frame_type             f_wdata, f_rdata;
   logic                  d_we;
   logic [DATA_AW-1:0]    d_waddr, d_raddr;
   logic [WORD_WIDTH-1:0] d_wdata, d_rdata;

   frvm_ram #(.WIDTH($bits(frame_type)), .DEPTH(FRAME_DEPTH)) u_frame_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   frvm_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DATA_DEPTH)) u_data_ram (
      .clock (clock),
      .we    (d_we),
      .waddr (d_waddr),
      .wdata (d_wdata),
      .raddr (d_raddr),
      .rdata (d_rdata)
   );

   logic                  req_xfer;
   logic [FRAME_AW-1:0]   top_idx, below_idx;
   logic [ASUM_W-1:0]     s_t, s_s, s_q, s_b, s_r, s_p;
   logic                  o_t, o_s, o_q, o_b, o_r;
   logic [1:0]            err_f2;
   logic [DATA_AW-1:0]    at_f2, as_f2;
   logic signed [SUM_W-1:0] add_sum, cst_ext;
   logic [WORD_WIDTH-1:0] clamp_val;
   logic [PC_WIDTH-1:0]   pc_inc, pc_jmp, pc_entry;
   result_type            res_d2;
   logic [PC_WIDTH-1:0]   npc_d2;
   logic                  out_free;

   assign req_xfer  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign top_idx   = FRAME_AW'(fcount_ff - FCOUNT_W'(1));
   assign below_idx = FRAME_AW'(fcount_ff - FCOUNT_W'(2));
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.next_address = rsp_ff.next_address;
   assign rsp_bus.stop         = rsp_ff.stop;
   assign rsp_bus.halted       = rsp_ff.halted;
   assign rsp_bus.error_code   = rsp_ff.error_code;

   // Address arithmetic and fault checks, done once the top and caller frames are read.
   always_comb begin
      s_t = ASUM_W'(top_ff.base) + ASUM_W'(tr_ff);
      s_s = ASUM_W'(top_ff.base) + ASUM_W'(sr_ff);
      s_q = ASUM_W'(top_ff.base) + ASUM_W'(qr_ff);
      s_b = ASUM_W'(f_rdata.base) + ASUM_W'(sr_ff);
      s_r = ASUM_W'(f_rdata.base) + ASUM_W'(top_ff.ret_reg);
      s_p = ASUM_W'(dtop_ff) + ASUM_W'(fsize_ff);
      o_t = s_t >= ASUM_W'(DATA_DEPTH);
      o_s = s_s >= ASUM_W'(DATA_DEPTH);
      o_q = s_q >= ASUM_W'(DATA_DEPTH);
      o_b = s_b >= ASUM_W'(DATA_DEPTH);
      o_r = s_r >= ASUM_W'(DATA_DEPTH);
      at_f2 = s_t[DATA_AW-1:0];
      as_f2 = s_s[DATA_AW-1:0];
      err_f2 = ERR_OK;
      case (op_ff)
         OP_ADDC, OP_TEST, OP_CONST, OP_JMPC: begin
            if (fcount_ff == '0) begin
               err_f2 = ERR_MISSING;
            end else if ((op_ff != OP_JMPC && o_t) || (op_ff != OP_CONST && o_s) ||
                         (op_ff == OP_TEST && o_q)) begin
               err_f2 = ERR_DATA;
            end
         end
         OP_EXEC: begin
            if (fcount_ff == '0) begin
               err_f2 = ERR_MISSING;
            end
         end
         OP_ARG: begin
            as_f2 = s_b[DATA_AW-1:0];
            if (fcount_ff < FCOUNT_W'(2)) begin
               err_f2 = ERR_MISSING;
            end else if (o_t || o_b) begin
               err_f2 = ERR_DATA;
            end
         end
         OP_RET: begin
            at_f2 = s_r[DATA_AW-1:0];
            if (fcount_ff < FCOUNT_W'(2)) begin
               err_f2 = ERR_MISSING;
            end else if (o_r || o_s) begin
               err_f2 = ERR_DATA;
            end
         end
         OP_PREPARE: begin
            if (32'(fcount_ff) >= 32'(FRAME_DEPTH)) begin
               err_f2 = ERR_FRAMES;
            end else if (s_p > ASUM_W'(DATA_DEPTH)) begin
               err_f2 = ERR_DATA;
            end
         end
         default: err_f2 = ERR_OK;
      endcase
   end

   // Saturating add, clamped to the non-negative range of a word, and the next program counter candidates.
   always_comb begin
      cst_ext = SUM_W'($signed(cst_ff));
      add_sum = SUM_W'($signed(adata_ff)) + cst_ext;
      if (add_sum < 0) begin
         clamp_val = '0;
      end else if (add_sum > $signed(SUM_W'(WORD_MAX))) begin
         clamp_val = WORD_MAX;
      end else begin
         clamp_val = add_sum[WORD_WIDTH-1:0];
      end
      pc_inc   = pc_ff + PC_WIDTH'(1);
      pc_jmp   = pc_ff + PC_WIDTH'(32'($signed(off_ff)));
      pc_entry = PC_WIDTH'(32'(entry_ff));
   end

   // Execute step: next program counter and result fields.
   always_comb begin
      npc_d2 = pc_inc;
      res_d2.stop = 1'b0;
      res_d2.halted = 1'b0;
      res_d2.error_code = err_ff;
      case (op_ff)
         OP_SOFTBRK: res_d2.stop = step_ff;
         OP_BREAK:   res_d2.stop = 1'b1;
         OP_HALT: begin
            res_d2.stop = 1'b1;
            res_d2.halted = 1'b1;
            npc_d2 = pc_ff;
         end
         OP_JMP:  npc_d2 = pc_jmp;
         OP_JMPC: npc_d2 = (adata_ff == '0) ? pc_jmp : pc_inc;
         OP_EXEC: npc_d2 = pc_entry;
         OP_RET:  npc_d2 = top_ff.link_pc;
         default: npc_d2 = pc_inc;
      endcase
      if (err_ff != ERR_OK) begin
         npc_d2 = pc_ff;
         res_d2.stop = 1'b1;
         res_d2.halted = 1'b0;
      end
      res_d2.next_address = 16'(32'(npc_d2));
   end

   // RAM port control.
   always_comb begin
      f_raddr = top_idx;
      d_raddr = as_f2;
      f_we = 1'b0;
      f_waddr = top_idx;
      f_wdata = top_ff;
      d_we = 1'b0;
      d_waddr = at_ff;
      d_wdata = adata_ff;
      case (state_ff)
         ST_F1: f_raddr = below_idx;
         ST_D1: d_raddr = aq_ff;
         ST_D2: begin
            if (err_ff == ERR_OK) begin
               case (op_ff)
                  OP_ADDC: begin
                     d_we = 1'b1;
                     d_wdata = clamp_val;
                  end
                  OP_TEST: begin
                     d_we = 1'b1;
                     d_wdata = (adata_ff == d_rdata) ? WORD_WIDTH'(0) : WORD_WIDTH'(1);
                  end
                  OP_CONST: begin
                     d_we = 1'b1;
                     d_wdata = cst_ext[WORD_WIDTH-1:0];
                  end
                  OP_ARG, OP_RET: d_we = 1'b1;
                  OP_EXEC: begin
                     f_we = 1'b1;
                     f_wdata.link_pc = pc_inc;
                  end
                  OP_PREPARE: begin
                     f_we = 1'b1;
                     f_waddr = FRAME_AW'(fcount_ff);
                     f_wdata.base = dtop_ff;
                     f_wdata.ret_reg = tr_ff;
                     f_wdata.link_pc = '0;
                  end
                  default: d_we = 1'b0;
               endcase
            end
         end
         ST_CLR: begin
            d_we = 1'b1;
            d_waddr = clr_addr_ff;
            d_wdata = '0;
         end
         default: f_we = 1'b0;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_F1;
         ST_F1:   state_in = ST_F2;
         ST_F2:   state_in = ST_D1;
         ST_D1:   state_in = ST_D2;
         ST_D2: begin
            if (err_ff == ERR_OK && op_ff == OP_PREPARE && fsize_ff != '0) begin
               state_in = ST_CLR;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_CLR:  if (clr_left_ff == 8'd1) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         fcount_ff    <= '0;
         dtop_ff      <= '0;
         step_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            step_ff <= csr_wdata;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_D2) begin
            pc_ff <= npc_d2;
            if (err_ff == ERR_OK && op_ff == OP_RET) begin
               fcount_ff <= fcount_ff - FCOUNT_W'(1);
               dtop_ff   <= (DATA_AW+1)'(top_ff.base);
            end
            if (err_ff == ERR_OK && op_ff == OP_PREPARE) begin
               fcount_ff <= fcount_ff + FCOUNT_W'(1);
               dtop_ff   <= dtop_ff + (DATA_AW+1)'(fsize_ff);
            end
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff    <= req_bus.opcode;
         tr_ff    <= req_bus.target_reg;
         sr_ff    <= req_bus.source_reg;
         qr_ff    <= req_bus.second_reg;
         cst_ff   <= req_bus.constant_value;
         off_ff   <= req_bus.jump_offset;
         fsize_ff <= req_bus.frame_size;
         entry_ff <= req_bus.entry_address;
      end
      if (state_ff == ST_F1) begin
         top_ff <= f_rdata;
      end
      if (state_ff == ST_F2) begin
         err_ff <= err_f2;
         at_ff  <= at_f2;
         aq_ff  <= s_q[DATA_AW-1:0];
      end
      if (state_ff == ST_D1) begin
         adata_ff <= d_rdata;
      end
      if (state_ff == ST_D2) begin
         res_ff      <= res_d2;
         clr_addr_ff <= dtop_ff[DATA_AW-1:0];
         clr_left_ff <= fsize_ff;
      end
      if (state_ff == ST_CLR) begin
         clr_addr_ff <= clr_addr_ff + DATA_AW'(1);
         clr_left_ff <= clr_left_ff - 8'd1;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_ff <= res_ff;
      end
   end

endmodule
